// ----- rtl/scancode_line_editor_macros.svh -----
// Assertion macros shared by the scan code line editor RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef SCANCODE_LINE_EDITOR_MACROS_SVH
`define SCANCODE_LINE_EDITOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLE_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sle_pkg.sv -----
// Package for the scan code line editor: result kinds, controller states,
// scan code constants and the set 1 US layout translation tables. No dependencies.
`timescale 1ns / 1ps

package sle_pkg;

  // Result kinds carried in the low bits of the output data.
  typedef enum logic [2:0] {
    KIND_ECHO_CHAR   = 3'd0,
    KIND_ECHO_BS     = 3'd1,
    KIND_SCROLL_UP   = 3'd2,
    KIND_SCROLL_DOWN = 3'd3,
    KIND_LINE_CHAR   = 3'd4,
    KIND_LINE_END    = 3'd5
  } kind_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LINE = 1'b1
  } state_t;

  // Scan codes of interest.
  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
  localparam logic [7:0] SC_PAGE_UP    = 8'h49;
  localparam logic [7:0] SC_PAGE_DOWN  = 8'h51;
  localparam logic [7:0] SC_BACKSPACE  = 8'h0E;
  localparam logic [7:0] SC_ENTER      = 8'h1C;
  localparam logic [7:0] SC_KEY_MAX    = 8'h39;

  localparam logic [6:0] ASCII_QMARK   = 7'h3F;
  localparam int unsigned KEY_COUNT    = 58;

  // Unshifted characters for scan codes 0x00 to 0x39.
  localparam logic [6:0] PLAIN_MAP [KEY_COUNT] = '{
    7'h3F, 7'h3F, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h3F, 7'h3F,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h3F, 7'h3F, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h3F, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h3F, 7'h3F,
    7'h3F, 7'h20
  };

  // Shifted characters for scan codes 0x00 to 0x39.
  localparam logic [6:0] UPPER_MAP [KEY_COUNT] = '{
    7'h3F, 7'h3F, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h3F, 7'h3F,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h3F, 7'h3F, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h3F, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h3F, 7'h3F,
    7'h3F, 7'h20
  };

  // Translates a make code to ASCII; codes past the table give a question mark.
  function automatic logic [6:0] key_to_ascii(input logic [5:0] code, input logic shift);
    logic [6:0] ch;
    ch = ASCII_QMARK;
    if ({2'b00, code} <= SC_KEY_MAX) begin
      ch = shift ? UPPER_MAP[code] : PLAIN_MAP[code];
    end
    return ch;
  endfunction

endpackage

// ----- rtl/scancode_line_editor.sv -----
// Scan code line editor: turns set 1 scan codes into echo, scroll and line items.
// Depends on sle_pkg and on scancode_line_editor_macros.svh for its assertions.
`timescale 1ns / 1ps

// Each accepted scan code is decoded in the cycle it is taken, and any single
// result it causes is loaded straight into the output register, so after a
// non-Enter item the next one can enter in the cycle that result is taken.
// Enter with characters stored walks the line store through its single
// synchronous read port, one character per cycle while the output does not
// stall, each read registered before it is handed out, and then gives the
// line end, with no input taken during that walk.
// The line store holds LINE_DEPTH - 1 characters; further keys are dropped.
`include "scancode_line_editor_macros.svh"

module scancode_line_editor
  import sle_pkg::*;
#(
  parameter int LINE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] scan_code
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [2:0] kind, [9:3] char_code, [15:10] zero
  output logic        out_tlast   // last
);

  localparam int FW = $clog2(LINE_DEPTH);
  localparam logic [FW-1:0] FILL_MAX = FW'(LINE_DEPTH - 1);

  // Control state.
  state_t        state_r, state_nxt;
  logic          shift_r, shift_nxt;
  logic [FW-1:0] fill_count_r, fill_count_nxt;
  logic [FW-1:0] rd_idx_r, rd_idx_nxt;
  logic [FW-1:0] len_r, len_nxt;
  logic          data_vld_r, data_vld_nxt;

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  kind_t         out_kind_r, out_kind_nxt;
  logic [6:0]    out_char_r, out_char_nxt;
  logic          out_last_r, out_last_nxt;

  // Line store.
  logic [6:0]    mem [LINE_DEPTH];
  logic [6:0]    rd_data_r;
  logic          mem_we;
  logic          rd_en;

  logic          slot_free;
  logic          in_acc;
  logic [7:0]    sc;
  logic [6:0]    key_ch;
  logic          consume;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign in_acc    = in_tvalid && in_tready;
  assign sc        = in_tdata;
  assign key_ch    = key_to_ascii(sc[5:0], shift_r);
  assign consume   = (state_r == ST_LINE) && data_vld_r && slot_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_char_r, out_kind_r};
  assign out_tlast  = out_last_r;

  // Decode, store update and line walk.
  always_comb begin
    state_nxt      = state_r;
    shift_nxt      = shift_r;
    fill_count_nxt = fill_count_r;
    rd_idx_nxt     = rd_idx_r;
    len_nxt        = len_r;
    data_vld_nxt   = data_vld_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    rd_en          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (sc == SC_LSHIFT || sc == SC_RSHIFT) begin
            shift_nxt = 1'b1;
          end else if (sc == SC_LSHIFT_BRK || sc == SC_RSHIFT_BRK) begin
            shift_nxt = 1'b0;
          end else if (sc[7]) begin
            // Other releases are ignored.
          end else if (sc == SC_PAGE_UP) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_SCROLL_UP;
            out_char_nxt  = '0;
            out_last_nxt  = 1'b1;
          end else if (sc == SC_PAGE_DOWN) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_SCROLL_DOWN;
            out_char_nxt  = '0;
            out_last_nxt  = 1'b1;
          end else if (sc == SC_BACKSPACE) begin
            if (fill_count_r != '0) begin
              fill_count_nxt = fill_count_r - 1'b1;
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = KIND_ECHO_BS;
              out_char_nxt   = '0;
              out_last_nxt   = 1'b1;
            end
          end else if (sc == SC_ENTER) begin
            if (fill_count_r == '0) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_LINE_END;
              out_char_nxt  = '0;
              out_last_nxt  = 1'b1;
            end else begin
              state_nxt      = ST_LINE;
              len_nxt        = fill_count_r;
              rd_idx_nxt     = '0;
              data_vld_nxt   = 1'b0;
              fill_count_nxt = '0;
            end
          end else if (sc <= SC_KEY_MAX) begin
            if (fill_count_r != FILL_MAX) begin
              mem_we         = 1'b1;
              fill_count_nxt = fill_count_r + 1'b1;
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = KIND_ECHO_CHAR;
              out_char_nxt   = key_ch;
              out_last_nxt   = 1'b1;
            end
          end
        end
      end
      ST_LINE: begin
        // Hand the prefetched character to the output register.
        if (consume) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_LINE_CHAR;
          out_char_nxt  = rd_data_r;
          out_last_nxt  = 1'b0;
          data_vld_nxt  = 1'b0;
        end
        // Issue the next read whenever the prefetch slot is or becomes empty.
        if ((rd_idx_r != len_r) && (!data_vld_r || consume)) begin
          rd_en        = 1'b1;
          rd_idx_nxt   = rd_idx_r + 1'b1;
          data_vld_nxt = 1'b1;
        end
        // All characters handed out: close the line.
        if ((rd_idx_r == len_r) && !data_vld_r && slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_LINE_END;
          out_char_nxt  = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      shift_r      <= 1'b0;
      fill_count_r <= '0;
      rd_idx_r     <= '0;
      len_r        <= '0;
      data_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      shift_r      <= shift_nxt;
      fill_count_r <= fill_count_nxt;
      rd_idx_r     <= rd_idx_nxt;
      len_r        <= len_nxt;
      data_vld_r   <= data_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Line store: written only while idle, read only during a line walk, so the
  // two never touch the same entry in the same cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_count_r] <= key_ch;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  // Assertions.
  `SLE_ASSERT(a_fill_bound, 1'b1, fill_count_r <= FILL_MAX, "fill count past store capacity")
  `SLE_ASSERT(a_fill_empty_walk, state_r == ST_LINE, fill_count_r == '0,
              "store not empty in walk")
  `SLE_ASSERT(a_rd_idx_bound, state_r == ST_LINE, rd_idx_r <= len_r, "read index past line length")
  `SLE_ASSERT(a_prefetch_src, data_vld_r, rd_idx_r != '0, "prefetched data without a read")
  `SLE_ASSERT_NEXT(a_enter_walk, in_acc && (sc == SC_ENTER) && (fill_count_r != '0),
                   state_r == ST_LINE, "enter did not start walk")

endmodule
